// ===== rtl/steer_guide_sweep_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the steering guide search checker
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STEER_GUIDE_SWEEP_SEARCH_ASSERT_SVH
`define STEER_GUIDE_SWEEP_SEARCH_ASSERT_SVH

// same-cycle implication
`define SGS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgs checker: same-cycle rule violated");

// next-cycle implication
`define SGS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgs checker: next-cycle rule violated");

`endif

// ===== rtl/sgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_pkg
// Widths, constants and shared types of the steering guide search.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int PosW    = 12;
  localparam int SpeedW  = 15;
  localparam int DriveW  = 16;
  localparam int HitsW   = 4;
  localparam int MarginW = 8;
  localparam int GainW   = 8;

  localparam int SEARCH_TICKS = 500;
  localparam int CENTER_TICKS = 300;
  localparam int DEADBAND     = 3;
  localparam int HITS_NEEDED  = 2;

  localparam int SearchTickW = $clog2(SEARCH_TICKS + 1);
  localparam int CenterTickW = $clog2(CENTER_TICKS + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  typedef struct packed {
    logic [PosW-1:0]    left_limit;
    logic [PosW-1:0]    right_limit;
    logic [PosW-1:0]    center_position;
    logic [MarginW-1:0] limit_margin;
    logic [SpeedW-1:0]  max_steer_speed;
    logic [SpeedW-1:0]  max_motor_speed;
    logic [GainW-1:0]   center_gain;
  } cfg_t;

  typedef struct packed {
    logic              start_req;
    logic              search_right_first;
    logic [SpeedW-1:0] sweep_speed;
    logic [PosW-1:0]   position_sample;
    logic [HitsW-1:0]  guide_hits;
    logic              abort_req;
  } item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive_speed;
    logic                     busy_res;
    logic                     finished;
    logic                     guide_found;
  } result_t;

endpackage

// ===== rtl/sgs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sgs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sgs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sgs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output sgs_pkg::cfg_t                 cfg_o
);

  localparam logic [sgs_pkg::CfgIdxW-1:0] RegLeftLimit  = 3'd0;
  localparam logic [sgs_pkg::CfgIdxW-1:0] RegRightLimit = 3'd1;
  localparam logic [sgs_pkg::CfgIdxW-1:0] RegCenterPos  = 3'd2;
  localparam logic [sgs_pkg::CfgIdxW-1:0] RegMargin     = 3'd3;
  localparam logic [sgs_pkg::CfgIdxW-1:0] RegMaxSteer   = 3'd4;
  localparam logic [sgs_pkg::CfgIdxW-1:0] RegMaxMotor   = 3'd5;
  localparam logic [sgs_pkg::CfgIdxW-1:0] RegGain       = 3'd6;

  sgs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLeftLimit:  cfg_d.left_limit      = cfg_wdata_i[sgs_pkg::PosW-1:0];
        RegRightLimit: cfg_d.right_limit     = cfg_wdata_i[sgs_pkg::PosW-1:0];
        RegCenterPos:  cfg_d.center_position = cfg_wdata_i[sgs_pkg::PosW-1:0];
        RegMargin:     cfg_d.limit_margin    = cfg_wdata_i[sgs_pkg::MarginW-1:0];
        RegMaxSteer:   cfg_d.max_steer_speed = cfg_wdata_i[sgs_pkg::SpeedW-1:0];
        RegMaxMotor:   cfg_d.max_motor_speed = cfg_wdata_i[sgs_pkg::SpeedW-1:0];
        RegGain:       cfg_d.center_gain     = cfg_wdata_i[sgs_pkg::GainW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_limit      <= 12'd1000;
      cfg_q.right_limit     <= 12'd3000;
      cfg_q.center_position <= 12'd2048;
      cfg_q.limit_margin    <= 8'd30;
      cfg_q.max_steer_speed <= 15'd1000;
      cfg_q.max_motor_speed <= 15'd2999;
      cfg_q.center_gain     <= 8'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/sgs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_core
// Search state and the per-tick step: sweep, limit tracking, centering.
// ----------------------------------------------------------------------------
module sgs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  sgs_pkg::cfg_t    cfg_i,
  input  sgs_pkg::item_t   item_i,
  output sgs_pkg::result_t res_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhSweep  = 2'd1;
  localparam logic [1:0] PhCenter = 2'd2;

  localparam int ProdW = sgs_pkg::PosW + sgs_pkg::GainW;
  localparam int CmpW  = sgs_pkg::PosW + 2;
  localparam int ErrW  = sgs_pkg::PosW + 1;

  logic [1:0]                        phase_q, phase_d;
  logic                              right_first_q, right_first_d;
  logic                              left_reached_q, left_reached_d;
  logic                              right_reached_q, right_reached_d;
  logic [sgs_pkg::SearchTickW-1:0]   sticks_q, sticks_d;
  logic [sgs_pkg::CenterTickW-1:0]   cticks_q, cticks_d;
  logic [sgs_pkg::SpeedW-1:0]        held_q, held_d;

  // clamp to both speed limits
  function automatic logic [sgs_pkg::SpeedW-1:0] limit_speed(
    input logic [ProdW-1:0]          v,
    input logic [sgs_pkg::SpeedW-1:0] max_steer,
    input logic [sgs_pkg::SpeedW-1:0] max_motor
  );
    logic [ProdW-1:0] r;
    r = v;
    if (r > ProdW'(max_steer)) r = ProdW'(max_steer);
    if (r > ProdW'(max_motor)) r = ProdW'(max_motor);
    return r[sgs_pkg::SpeedW-1:0];
  endfunction

  logic                              hit;
  logic signed [CmpW-1:0]            pos_s, lt_s, rt_s;
  logic                              left_far, right_far;
  logic signed [ErrW-1:0]            err;
  logic [sgs_pkg::PosW-1:0]          mag;
  logic [ProdW-1:0]                  prod;
  logic [sgs_pkg::SpeedW-1:0]        held_eff;
  logic [sgs_pkg::SpeedW-1:0]        v_sweep, v_center;
  logic signed [sgs_pkg::DriveW-1:0] pos_sweep, pos_center;
  logic                              enter_center;
  logic [sgs_pkg::CenterTickW-1:0]   cticks_eff;
  logic [1:0]                        phase_eff;

  assign hit   = item_i.guide_hits >= sgs_pkg::HitsW'(sgs_pkg::HITS_NEEDED);
  assign pos_s = $signed(CmpW'(item_i.position_sample));
  assign lt_s  = $signed(CmpW'(cfg_i.left_limit)) + $signed(CmpW'(cfg_i.limit_margin));
  // signed on purpose: a margin beyond the limit goes negative
  assign rt_s  = $signed(CmpW'(cfg_i.right_limit)) - $signed(CmpW'(cfg_i.limit_margin));
  assign left_far  = pos_s > lt_s;
  assign right_far = pos_s < rt_s;

  assign err  = $signed(ErrW'(item_i.position_sample)) - $signed(ErrW'(cfg_i.center_position));
  assign mag  = err[ErrW-1] ? sgs_pkg::PosW'(-err) : sgs_pkg::PosW'(err);
  assign prod = ProdW'(mag) * ProdW'(cfg_i.center_gain);

  // speed of this tick: a start latches the new one
  assign held_eff   = item_i.start_req ? item_i.sweep_speed : held_q;
  assign v_sweep    = limit_speed(ProdW'(held_eff), cfg_i.max_steer_speed,
                                  cfg_i.max_motor_speed);
  assign v_center   = limit_speed(prod, cfg_i.max_steer_speed, cfg_i.max_motor_speed);
  assign pos_sweep  = $signed(sgs_pkg::DriveW'(v_sweep));
  assign pos_center = $signed(sgs_pkg::DriveW'(v_center));

  always_comb begin
    phase_d         = phase_q;
    right_first_d   = right_first_q;
    left_reached_d  = left_reached_q;
    right_reached_d = right_reached_q;
    sticks_d        = sticks_q;
    cticks_d        = cticks_q;
    held_d          = held_q;
    res_o           = '0;
    enter_center    = 1'b0;

    // a start restarts the search and is itself the first sweep tick
    if (item_i.start_req) begin
      right_first_d   = item_i.search_right_first;
      held_d          = item_i.sweep_speed;
      left_reached_d  = 1'b0;
      right_reached_d = 1'b0;
      sticks_d        = sgs_pkg::SearchTickW'(sgs_pkg::SEARCH_TICKS);
      phase_d         = PhSweep;
    end
    phase_eff = phase_d;

    if (phase_eff == PhSweep) begin
      if (hit) begin
        phase_d           = PhIdle;
        res_o.finished    = 1'b1;
        res_o.guide_found = 1'b1;
      end else if (sticks_d == '0 || item_i.abort_req) begin
        if (sticks_d != '0) sticks_d = sticks_d - 1'b1;
        phase_d        = PhIdle;
        res_o.finished = 1'b1;
      end else begin
        sticks_d       = sticks_d - 1'b1;
        res_o.busy_res = 1'b1;
        if (!right_first_d) begin
          if (!left_reached_d) begin
            if (left_far) res_o.drive_speed = -pos_sweep;
            else begin
              left_reached_d    = 1'b1;
              res_o.drive_speed = pos_sweep;
            end
          end else if (!right_reached_d) begin
            if (right_far) res_o.drive_speed = pos_sweep;
            else right_reached_d = 1'b1;
          end else begin
            enter_center = 1'b1;
          end
        end else begin
          if (!right_reached_d) begin
            if (right_far) res_o.drive_speed = pos_sweep;
            else begin
              right_reached_d   = 1'b1;
              res_o.drive_speed = -pos_sweep;
            end
          end else if (!left_reached_d) begin
            if (left_far) res_o.drive_speed = -pos_sweep;
            else left_reached_d = 1'b1;
          end else begin
            enter_center = 1'b1;
          end
        end
      end
    end

    cticks_eff = enter_center ? sgs_pkg::CenterTickW'(sgs_pkg::CENTER_TICKS) : cticks_q;

    if (phase_eff == PhCenter || enter_center) begin
      res_o = '0;
      if (mag <= sgs_pkg::PosW'(sgs_pkg::DEADBAND) || cticks_eff == '0) begin
        phase_d           = PhIdle;
        cticks_d          = cticks_eff;
        res_o.finished    = 1'b1;
        res_o.guide_found = hit;
      end else begin
        phase_d           = PhCenter;
        cticks_d          = cticks_eff - 1'b1;
        res_o.busy_res    = 1'b1;
        res_o.drive_speed = (err > 0) ? -pos_center : pos_center;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhIdle;
      right_first_q   <= 1'b0;
      left_reached_q  <= 1'b0;
      right_reached_q <= 1'b0;
      sticks_q        <= '0;
      cticks_q        <= '0;
      held_q          <= '0;
    end else if (step_en_i) begin
      phase_q         <= phase_d;
      right_first_q   <= right_first_d;
      left_reached_q  <= left_reached_d;
      right_reached_q <= right_reached_d;
      sticks_q        <= sticks_d;
      cticks_q        <= cticks_d;
      held_q          <= held_d;
    end
  end

endmodule

// ===== rtl/steer_guide_sweep_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steer_guide_sweep_search
// Steering-axle guide search, one control tick per input request.
// ----------------------------------------------------------------------------
// Each accepted request is one 10 ms control tick and yields exactly one
// result. A request lands in an input register, is evaluated by the single
// step of sgs_core (sweep, limit flags, centering with an 12x8 multiply and
// clamp); the result is captured in an output register as the tick advances,
// which waits while an untaken result is held. One request per cycle is
// sustained while results are taken. Configuration writes take effect at once
// and belong in idle periods.
module steer_guide_sweep_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sgs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sgs_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               start_req_i,
  input  logic                               search_right_first_i,
  input  logic [sgs_pkg::SpeedW-1:0]         sweep_speed_i,
  input  logic [sgs_pkg::PosW-1:0]           position_sample_i,
  input  logic [sgs_pkg::HitsW-1:0]          guide_hits_i,
  input  logic                               abort_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sgs_pkg::DriveW-1:0]  drive_speed_o,
  output logic                               busy_res_o,
  output logic                               finished_o,
  output logic                               guide_found_o
);

  sgs_pkg::cfg_t    cfg;
  sgs_pkg::item_t   item_q;
  sgs_pkg::result_t step_res;
  sgs_pkg::result_t res_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             advance, in_take;

  sgs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // tick moves from input register to output register
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  sgs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .res_o     (step_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.start_req          <= start_req_i;
      item_q.search_right_first <= search_right_first_i;
      item_q.sweep_speed        <= sweep_speed_i;
      item_q.position_sample    <= position_sample_i;
      item_q.guide_hits         <= guide_hits_i;
      item_q.abort_req          <= abort_i;
    end
    if (advance) res_q <= step_res;
  end

  assign out_valid_o   = out_valid_q;
  assign drive_speed_o = res_q.drive_speed;
  assign busy_res_o    = res_q.busy_res;
  assign finished_o    = res_q.finished;
  assign guide_found_o = res_q.guide_found;

endmodule

// ===== rtl/sgs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_checker
// Port-level checks of the steering guide search, bound to the top level.
// ----------------------------------------------------------------------------
`include "steer_guide_sweep_search_assert.svh"

module sgs_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic signed [sgs_pkg::DriveW-1:0]  drive_speed_o,
  input  logic                               busy_res_o,
  input  logic                               finished_o,
  input  logic                               guide_found_o
);

  // a finishing tick is never still busy
  `SGS_ASSERT_IMP(a_fin_not_busy, out_valid_o && finished_o, !busy_res_o)
  // found only reported on the finishing tick
  `SGS_ASSERT_IMP(a_found_needs_fin, out_valid_o && guide_found_o, finished_o)
  // motors stopped whenever nothing is running
  `SGS_ASSERT_IMP(a_idle_no_drive, out_valid_o && !busy_res_o, drive_speed_o == 16'sd0)
  // a pending result is held until taken
  `SGS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind steer_guide_sweep_search sgs_checker u_sgs_checker (.*);

// ===== tb/sgs_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_tb_pkg
// Register map of the steering guide search config port, shared by the
// stimulus and the checker.
// ----------------------------------------------------------------------------
package sgs_tb_pkg;

  typedef enum logic [sgs_pkg::CfgIdxW-1:0] {
    REG_LEFT_LIMIT,
    REG_RIGHT_LIMIT,
    REG_CENTER_POSITION,
    REG_LIMIT_MARGIN,
    REG_MAX_STEER_SPEED,
    REG_MAX_MOTOR_SPEED,
    REG_CENTER_GAIN
  } steer_reg_e;

endpackage

// ===== tb/sgs_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_search_checker
// Watches the config port and the request and result channels of the search,
// predicts the command of every accepted tick and compares it in order.
// ----------------------------------------------------------------------------
module sgs_search_checker
  import sgs_pkg::*, sgs_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     start_req_i,
  input  logic                     search_right_first_i,
  input  logic [SpeedW-1:0]        sweep_speed_i,
  input  logic [PosW-1:0]          position_sample_i,
  input  logic [HitsW-1:0]         guide_hits_i,
  input  logic                     abort_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DriveW-1:0] drive_speed_i,
  input  logic                     busy_res_i,
  input  logic                     finished_i,
  input  logic                     guide_found_i,
  output int                       fail_count_o,
  output int                       outstanding_o
);

  typedef enum logic [1:0] {
    SEARCH_IDLE,
    SEARCH_SWEEP,
    SEARCH_CENTER
  } search_phase_e;

  // mirrored config
  logic [PosW-1:0]    left_lim, right_lim, center_pos;
  logic [MarginW-1:0] margin;
  logic [SpeedW-1:0]  max_steer, max_motor;
  logic [GainW-1:0]   gain;

  // mirrored search state
  search_phase_e          phase;
  logic                   right_first, left_reached, right_reached;
  logic [SearchTickW-1:0] search_left;
  logic [CenterTickW-1:0] center_left;
  logic [SpeedW-1:0]      held_speed;

  result_t pending_commands[$];
  item_t   seen;
  result_t got, want;
  int      reported;

  function automatic int clamp_speed(input int req);
    int v;
    v = req;
    if (v > int'(max_steer)) v = int'(max_steer);
    if (v > int'(max_motor)) v = int'(max_motor);
    return v;
  endfunction

  function automatic result_t next_steer_command(input item_t it);
    result_t r;
    int      pos, lt, rt, v, drv, err, mag;
    logic    hit;
    r   = '0;
    drv = 0;
    pos = int'(it.position_sample);
    hit = int'(it.guide_hits) >= HITS_NEEDED;
    lt  = int'(left_lim) + int'(margin);
    // may go negative: a big margin makes the right end count as reached
    rt  = int'(right_lim) - int'(margin);

    if (it.start_req) begin
      right_first   = it.search_right_first;
      held_speed    = it.sweep_speed;
      left_reached  = 1'b0;
      right_reached = 1'b0;
      search_left   = SearchTickW'(SEARCH_TICKS);
      phase         = SEARCH_SWEEP;
    end

    if (phase == SEARCH_SWEEP) begin
      // hits win over budget and abort
      if (hit) begin
        phase         = SEARCH_IDLE;
        r.finished    = 1'b1;
        r.guide_found = 1'b1;
        return r;
      end
      if (search_left == 0 || it.abort_req) begin
        if (search_left != 0) search_left--;
        phase      = SEARCH_IDLE;
        r.finished = 1'b1;
        return r;
      end
      search_left--;
      v = clamp_speed(int'(held_speed));
      if (!right_first) begin
        if (!left_reached) begin
          if (pos > lt) drv = -v;
          else begin
            left_reached = 1'b1;
            drv          = v;
          end
        end else if (!right_reached) begin
          if (pos < rt) drv = v;
          else right_reached = 1'b1;
        end else begin
          phase       = SEARCH_CENTER;
          center_left = CenterTickW'(CENTER_TICKS);
        end
      end else begin
        if (!right_reached) begin
          if (pos < rt) drv = v;
          else begin
            right_reached = 1'b1;
            drv           = -v;
          end
        end else if (!left_reached) begin
          if (pos > lt) drv = -v;
          else left_reached = 1'b1;
        end else begin
          phase       = SEARCH_CENTER;
          center_left = CenterTickW'(CENTER_TICKS);
        end
      end
      if (phase == SEARCH_SWEEP) begin
        r.drive_speed = DriveW'(drv);
        r.busy_res    = 1'b1;
        return r;
      end
    end

    // abort has no effect here
    if (phase == SEARCH_CENTER) begin
      err = pos - int'(center_pos);
      mag = (err < 0) ? -err : err;
      if (mag <= DEADBAND || center_left == 0) begin
        phase         = SEARCH_IDLE;
        r.finished    = 1'b1;
        r.guide_found = hit;
        return r;
      end
      center_left--;
      v             = clamp_speed(mag * int'(gain));
      drv           = (err > 0) ? -v : v;
      r.drive_speed = DriveW'(drv);
      r.busy_res    = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_lim      = PosW'(1000);
      right_lim     = PosW'(3000);
      center_pos    = PosW'(2048);
      margin        = MarginW'(30);
      max_steer     = SpeedW'(1000);
      max_motor     = SpeedW'(2999);
      gain          = GainW'(10);
      phase         = SEARCH_IDLE;
      right_first   = 1'b0;
      left_reached  = 1'b0;
      right_reached = 1'b0;
      search_left   = '0;
      center_left   = '0;
      held_speed    = '0;
      pending_commands.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      reported      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.drive_speed = drive_speed_i;
        got.busy_res    = busy_res_i;
        got.finished    = finished_i;
        got.guide_found = guide_found_i;
        if (pending_commands.size() == 0) begin
          fail_count_o++;
          if (reported < 10)
            $display("%0t: result with no request waiting: drive %0d busy %0b fin %0b found %0b",
                     $realtime, got.drive_speed, got.busy_res, got.finished, got.guide_found);
          reported++;
        end else begin
          want = pending_commands.pop_front();
          if (got.drive_speed !== want.drive_speed || got.busy_res !== want.busy_res ||
              got.finished !== want.finished || got.guide_found !== want.guide_found) begin
            fail_count_o++;
            if (reported < 10)
              $display("%0t: mismatch drive %0d/%0d busy %0b/%0b fin %0b/%0b found %0b/%0b %s",
                       $realtime, want.drive_speed, got.drive_speed, want.busy_res,
                       got.busy_res, want.finished, got.finished, want.guide_found,
                       got.guide_found, "(expected/actual)");
            reported++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LEFT_LIMIT:      left_lim   = cfg_wdata_i[PosW-1:0];
          REG_RIGHT_LIMIT:     right_lim  = cfg_wdata_i[PosW-1:0];
          REG_CENTER_POSITION: center_pos = cfg_wdata_i[PosW-1:0];
          REG_LIMIT_MARGIN:    margin     = cfg_wdata_i[MarginW-1:0];
          REG_MAX_STEER_SPEED: max_steer  = cfg_wdata_i[SpeedW-1:0];
          REG_MAX_MOTOR_SPEED: max_motor  = cfg_wdata_i[SpeedW-1:0];
          REG_CENTER_GAIN:     gain       = cfg_wdata_i[GainW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        seen.start_req          = start_req_i;
        seen.search_right_first = search_right_first_i;
        seen.sweep_speed        = sweep_speed_i;
        seen.position_sample    = position_sample_i;
        seen.guide_hits         = guide_hits_i;
        seen.abort_req          = abort_i;
        pending_commands.push_back(next_steer_command(seen));
      end
      outstanding_o = pending_commands.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for steer_guide_sweep_search: directed ticks, then
// randomized search episodes under several register settings, with bursty
// requests, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import sgs_pkg::*;
  import sgs_tb_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 60;
  localparam int NUM_SETTINGS = 6;
  localparam int SETTING_TICKS = 90;
  localparam int POS_MAX      = (1 << PosW) - 1;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]      cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     start_req_i;
  logic                     search_right_first_i;
  logic [SpeedW-1:0]        sweep_speed_i;
  logic [PosW-1:0]          position_sample_i;
  logic [HitsW-1:0]         guide_hits_i;
  logic                     abort_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DriveW-1:0] drive_speed_o;
  logic                     busy_res_o;
  logic                     finished_o;
  logic                     guide_found_o;

  int   fail_count, outstanding;
  int   burst_left = 0;
  int   ticks_sent = 0;
  int   quiet = 0;
  logic hold_req = 1'b0;
  logic hold_served = 1'b0;

  // copies of the programmed limits, used to plan sweep positions
  int cfg_left = 1000, cfg_right = 3000, cfg_center = 2048, cfg_margin = 30;

  always #5 clk_i = ~clk_i;

  steer_guide_sweep_search dut (.*);

  sgs_search_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .start_req_i, .search_right_first_i, .sweep_speed_i, .position_sample_i,
    .guide_hits_i, .abort_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .drive_speed_i(drive_speed_o), .busy_res_i(busy_res_o),
    .finished_i(finished_o), .guide_found_i(guide_found_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  function automatic int clamp_pos(input int p);
    if (p < 0) return 0;
    if (p > POS_MAX) return POS_MAX;
    return p;
  endfunction

  function automatic int between_limits();
    int lo, hi;
    lo = cfg_left + cfg_margin + 1;
    hi = cfg_right - cfg_margin - 1;
    if (lo <= hi) return $urandom_range(lo, hi);
    return $urandom_range(0, POS_MAX);
  endfunction

  function automatic int past_right();
    int rt;
    rt = cfg_right - cfg_margin;
    if (rt < 0) rt = 0;
    return $urandom_range(rt, POS_MAX);
  endfunction

  function automatic int past_left();
    int lt;
    lt = cfg_left + cfg_margin;
    if (lt > POS_MAX) lt = POS_MAX;
    return $urandom_range(0, lt);
  endfunction

  // mostly 0 or 1 sensor points, now and then a real hit
  function automatic logic [HitsW-1:0] pick_hits();
    if ($urandom_range(1, 60) == 1) return HitsW'($urandom_range(2, 15));
    return HitsW'($urandom_range(0, 1));
  endfunction

  function automatic logic pick_abort();
    return $urandom_range(1, 80) == 1;
  endfunction

  task automatic send_tick(input logic st, input logic dir, input logic [SpeedW-1:0] spd,
                           input int pos, input logic [HitsW-1:0] hits, input logic ab);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst_left = $urandom_range(1, 25);
      end
    end
    burst_left--;
    start_req_i          = st;
    search_right_first_i = dir;
    sweep_speed_i        = spd;
    position_sample_i    = PosW'(clamp_pos(pos));
    guide_hits_i         = hits;
    abort_i              = ab;
    in_valid_i           = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // sweep tick, with an occasional restart
  task automatic leg_tick(input int pos);
    send_tick($urandom_range(1, 70) == 1, 1'($urandom), SpeedW'($urandom), pos,
              pick_hits(), pick_abort());
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input steer_reg_e idx, input int val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = CfgDataW'(val);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic apply_setting(input int k);
    int l, r, c, m, s, mo, g;
    case (k)
      0: begin l = 1000; r = 3000; c = 2048; m = 30; s = 1000; mo = 2999; g = 10; end
      1: begin
        l = $urandom_range(200, 1500);  r = $urandom_range(2500, 3900);
        c = $urandom_range(1600, 2500); m = $urandom_range(0, 255);
        s = $urandom_range(0, 32767);   mo = $urandom_range(0, 32767);
        g = $urandom_range(0, 255);
      end
      2: begin l = 0; r = 4095; c = 4095; m = 255; s = 32767; mo = 32767; g = 255; end
      3: begin l = 0; r = 0; c = 0; m = 0; s = 0; mo = 0; g = 0; end
      // margin beyond both limits: each end counts as reached at once
      4: begin l = 4095; r = 100; c = 2048; m = 255; s = 32767; mo = 5; g = 1; end
      default: begin
        l = $urandom_range(0, 1500);    r = $urandom_range(2000, 4095);
        c = $urandom_range(0, 4095);    m = $urandom_range(0, 255);
        s = $urandom_range(0, 32767);   mo = $urandom_range(0, s);
        g = $urandom_range(0, 255);
      end
    endcase
    cfg_write(REG_LEFT_LIMIT, l);
    cfg_write(REG_RIGHT_LIMIT, r);
    cfg_write(REG_CENTER_POSITION, c);
    cfg_write(REG_LIMIT_MARGIN, m);
    cfg_write(REG_MAX_STEER_SPEED, s);
    cfg_write(REG_MAX_MOTOR_SPEED, mo);
    cfg_write(REG_CENTER_GAIN, g);
    cfg_left = l; cfg_right = r; cfg_center = c; cfg_margin = m;
  endtask

  task automatic run_directed();
    int c;
    c = cfg_center;
    send_tick(1'b0, 1'b0, '0, 0, 4'd0, 1'b0);
    send_tick(1'b0, 1'b1, SpeedW'(32767), POS_MAX, 4'd15, 1'b1);
    send_tick(1'b1, 1'b0, SpeedW'(800), 2000, 4'd2, 1'b0);
    send_tick(1'b1, 1'b1, SpeedW'(800), 2000, 4'd1, 1'b1);
    // left first through both ends, then straight into the deadband
    send_tick(1'b1, 1'b0, SpeedW'(32767), 2000, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, cfg_left + cfg_margin, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, cfg_right - cfg_margin, 4'd1, 1'b0);
    send_tick(1'b0, 1'b0, '0, c + 2, 4'd0, 1'b0);
    // right first, centering with abort ignored, found on the last tick
    send_tick(1'b1, 1'b1, '0, POS_MAX, 4'd0, 1'b0);
    send_tick(1'b1, 1'b1, SpeedW'(600), POS_MAX, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, 0, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, c + 500, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, c - 50, 4'd1, 1'b1);
    send_tick(1'b0, 1'b0, '0, c - 4, 4'd1, 1'b0);
    send_tick(1'b0, 1'b0, '0, c + 3, 4'd3, 1'b0);
    // restart while busy, then abort
    send_tick(1'b1, 1'b0, SpeedW'(500), 2000, 4'd0, 1'b0);
    send_tick(1'b1, 1'b1, SpeedW'(500), 2000, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, 2000, 4'd0, 1'b1);
    send_tick(1'b1, 1'b0, SpeedW'(700), 0, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, POS_MAX, 4'd8, 1'b0);
    send_tick(1'b0, 1'b0, '0, 1234, 4'd9, 1'b0);
  endtask

  task automatic search_episode();
    logic              dir;
    logic [SpeedW-1:0] spd;
    int                err;
    dir = 1'($urandom);
    spd = $urandom_range(0, 1) ? SpeedW'($urandom) : SpeedW'($urandom_range(0, 1500));
    send_tick(1'b1, dir, spd, between_limits(), pick_hits(), pick_abort());
    repeat ($urandom_range(0, 8)) leg_tick(between_limits());
    leg_tick(dir ? past_right() : past_left());
    repeat ($urandom_range(0, 8)) leg_tick(between_limits());
    leg_tick(dir ? past_left() : past_right());
    err = int'($urandom_range(0, 1800)) - 900;
    while (err > 3 || err < -3) begin
      leg_tick(cfg_center + err);
      err = err * int'($urandom_range(1, 3)) / 4;
    end
    leg_tick(cfg_center + int'($urandom_range(0, 6)) - 3);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 12))
      send_tick($urandom_range(0, 7) == 0, 1'($urandom), SpeedW'($urandom),
                $urandom_range(0, POS_MAX), HitsW'($urandom_range(0, 15)),
                $urandom_range(0, 3) == 0);
  endtask

  // stays between the ends until the tick budget is gone
  task automatic budget_run();
    send_tick(1'b1, 1'($urandom), SpeedW'($urandom), between_limits(), 4'd0, 1'b0);
    repeat (SEARCH_TICKS + 2)
      send_tick(1'b0, 1'($urandom), SpeedW'($urandom), between_limits(),
                HitsW'($urandom_range(0, 1)), 1'b0);
  endtask

  // reaches both ends, then never settles so centering times out
  task automatic center_timeout_run();
    int far;
    far = (cfg_center + 400 <= POS_MAX) ? cfg_center + 400 : cfg_center - 400;
    send_tick(1'b1, 1'b1, SpeedW'($urandom), POS_MAX, 4'd0, 1'b0);
    send_tick(1'b0, 1'b0, '0, 0, 4'd1, 1'b0);
    send_tick(1'b0, 1'b0, '0, far, 4'd0, 1'b0);
    repeat (CENTER_TICKS + 2)
      send_tick(1'b0, 1'($urandom), SpeedW'($urandom), far,
                HitsW'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
  endtask

  initial begin : stim_proc
    int k, stop;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_wdata_i          = '0;
    in_valid_i           = 1'b0;
    start_req_i          = 1'b0;
    search_right_first_i = 1'b0;
    sweep_speed_i        = '0;
    position_sample_i    = '0;
    guide_hits_i         = '0;
    abort_i              = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    drain();
    for (k = 0; k < NUM_SETTINGS; k++) begin
      apply_setting(k);
      if (k == 0) begin
        budget_run();
        drain();
        center_timeout_run();
      end
      if (k == 1) hold_req = 1'b1;
      stop = ticks_sent + SETTING_TICKS;
      while (ticks_sent < stop) begin
        if ($urandom_range(0, 9) == 0) noise_burst();
        else search_episode();
      end
      drain();
    end
    repeat (8) @(negedge clk_i);

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : recv_proc
    int stretch, mode, i;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stretch = $urandom_range(16, 120);
      mode    = $urandom_range(0, 3);
      for (i = 0; i < stretch; i++) begin
        @(negedge clk_i);
        // one long hold-off so the block backs up into its input
        if (hold_req && !hold_served) begin
          hold_served = 1'b1;
          out_ready_i = 1'b0;
          repeat (LONG_HOLD) @(negedge clk_i);
        end
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = $urandom_range(0, 9) < 7;
          2:       out_ready_i = (i % 4) != 3;
          default: out_ready_i = $urandom_range(0, 9) < 3;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
